>>> src/lrip_pkg.sv
// ----------------------------------------------------------------------------
// lrip_pkg
// Types and constants shared by the range-image projection pipeline.
// ----------------------------------------------------------------------------
package lrip_pkg;

   // Point coordinates and derived magnitudes.
   localparam int COORD_W = 18;
   localparam int SQ_W    = 35;
   localparam int HSQ_W   = 36;
   localparam int RSQ_W   = 36;
   localparam int RNG_W   = 18;
   localparam int HX_W    = 26;

   // Angles are kept in 1/256 centidegree.
   localparam int CORDIC_IN_W   = 27;
   localparam int CORDIC_XY_W   = 30;
   localparam int ANGLE_W       = 25;
   localparam int CORDIC_ITER   = 22;
   localparam int CORDIC_LAT    = CORDIC_ITER + 1;
   localparam int ATAN_W        = 21;
   localparam logic signed [ANGLE_W-1:0] DEG90 = 25'sd2304000;

   localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_ITER] = '{
      21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
      21'd22916,   21'd11459,  21'd5730,   21'd2865,   21'd1432,  21'd716,
      21'd358,     21'd179,    21'd90,     21'd45,     21'd22,    21'd11,
      21'd6,       21'd3,      21'd1,      21'd1
   };

   // Quotient and divisor widths of the row and column dividers.
   localparam int DIV_NUM_W = 16;
   localparam int DIV_DEN_W = 14;

   // Control and status registers.
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int LOW_ELEV_W   = 15;
   localparam int STEP_W       = 14;
   localparam int MIN_RANGE_W  = 17;

   localparam logic signed [LOW_ELEV_W-1:0] LOW_ELEV_RESET  = -15'sd1500;
   localparam logic [STEP_W-1:0]            ELEV_STEP_RESET = 14'd200;
   localparam logic [STEP_W-1:0]            AZIM_STEP_RESET = 14'd20;
   localparam logic [MIN_RANGE_W-1:0]       MIN_RANGE_RESET = 17'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOWEST_ELEVATION = 2'd0,
      CSR_ELEVATION_STEP   = 2'd1,
      CSR_AZIMUTH_STEP     = 2'd2,
      CSR_MIN_RANGE        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REJ_NONE = 2'd0,
      REJ_ROW  = 2'd1,
      REJ_COL  = 2'd2,
      REJ_NEAR = 2'd3
   } reject_code_type;

endpackage

>>> src/lrip_isqrt.sv
// ----------------------------------------------------------------------------
// lrip_isqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module lrip_isqrt #(
   parameter int RootW = 18
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [2*RootW-1:0]   radicand,
   output logic [RootW-1:0]     root
);

   localparam int NW   = 2 * RootW;
   localparam int RemW = RootW + 1;
   localparam int ShW  = RootW + 3;

   logic [RemW-1:0]  rem_ff  [RootW];
   logic [RootW-1:0] root_ff [RootW];
   logic [NW-1:0]    n_ff    [RootW];

   for (genvar j = 0; j < RootW; j++) begin : g_step
      logic [RemW-1:0]  rem_src;
      logic [RootW-1:0] root_src;
      logic [NW-1:0]    n_src;
      logic [ShW-1:0]   sh;
      logic [ShW-1:0]   trial;
      logic [ShW-1:0]   diff;
      logic             ge;

      if (j == 0) begin : g_head
         assign rem_src  = '0;
         assign root_src = '0;
         assign n_src    = radicand;
      end else begin : g_body
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign n_src    = n_ff[j-1];
      end

      // Bring in the next two radicand bits and try the trial subtrahend 4r+1.
      assign sh    = {rem_src, n_src[NW-1:NW-2]};
      assign trial = {1'b0, root_src, 2'b01};
      assign ge    = (sh >= trial);
      assign diff  = sh - trial;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= ge ? diff[RemW-1:0] : sh[RemW-1:0];
            root_ff[j] <= {root_src[RootW-2:0], ge};
            n_ff[j]    <= {n_src[NW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RootW-1];

endmodule

>>> src/lrip_cordic.sv
// ----------------------------------------------------------------------------
// lrip_cordic
// Pipelined vectoring CORDIC: angle of the vector (b, a) in 1/256 centidegree.
// ----------------------------------------------------------------------------
module lrip_cordic (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [lrip_pkg::CORDIC_IN_W-1:0] in_a,
   input  logic signed [lrip_pkg::CORDIC_IN_W-1:0] in_b,
   output logic signed [lrip_pkg::ANGLE_W-1:0]     angle
);

   localparam int IW   = lrip_pkg::CORDIC_IN_W;
   localparam int XW   = lrip_pkg::CORDIC_XY_W;
   localparam int AW   = lrip_pkg::ANGLE_W;
   localparam int ITER = lrip_pkg::CORDIC_ITER;

   logic signed [XW-1:0] re_ff   [ITER+1];
   logic signed [XW-1:0] im_ff   [ITER+1];
   logic signed [AW-1:0] ang_ff  [ITER+1];
   logic                 zero_ff [ITER+1];

   // Left half-plane vectors are turned by a quarter turn first.
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= (in_a == '0) && (in_b == '0);
         if (in_b[IW-1]) begin
            if (!in_a[IW-1]) begin
               re_ff[0]  <= XW'(in_a);
               im_ff[0]  <= -XW'(in_b);
               ang_ff[0] <= lrip_pkg::DEG90;
            end else begin
               re_ff[0]  <= -XW'(in_a);
               im_ff[0]  <= XW'(in_b);
               ang_ff[0] <= -lrip_pkg::DEG90;
            end
         end else begin
            re_ff[0]  <= XW'(in_b);
            im_ff[0]  <= XW'(in_a);
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic signed [XW-1:0] dre;
      logic signed [XW-1:0] dim;
      logic signed [AW-1:0] dang;

      assign dre  = im_ff[i] >>> i;
      assign dim  = re_ff[i] >>> i;
      assign dang = AW'(lrip_pkg::ATAN_TAB[i]);

      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!im_ff[i][XW-1]) begin
               re_ff[i+1]  <= re_ff[i] + dre;
               im_ff[i+1]  <= im_ff[i] - dim;
               ang_ff[i+1] <= ang_ff[i] + dang;
            end else begin
               re_ff[i+1]  <= re_ff[i] - dre;
               im_ff[i+1]  <= im_ff[i] + dim;
               ang_ff[i+1] <= ang_ff[i] - dang;
            end
         end
      end
   end

   // The zero vector has no direction and is defined to give angle zero.
   assign angle = zero_ff[ITER] ? '0 : ang_ff[ITER];

endmodule

>>> src/lrip_div.sv
// ----------------------------------------------------------------------------
// lrip_div
// Pipelined restoring divider, one quotient bit per stage, floor quotient.
// ----------------------------------------------------------------------------
module lrip_div (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [lrip_pkg::DIV_NUM_W-1:0]     dividend,
   input  logic [lrip_pkg::DIV_DEN_W-1:0]     divisor,
   output logic [lrip_pkg::DIV_NUM_W-1:0]     quotient
);

   localparam int NW = lrip_pkg::DIV_NUM_W;
   localparam int DW = lrip_pkg::DIV_DEN_W;

   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [NW-1:0] n_ff   [NW];
   logic [NW-1:0] q_ff   [NW];

   for (genvar j = 0; j < NW; j++) begin : g_step
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [NW-1:0] n_src;
      logic [NW-1:0] q_src;
      logic [DW:0]   sh;
      logic [DW:0]   diff;
      logic          ge;

      if (j == 0) begin : g_head
         assign rem_src = '0;
         assign den_src = divisor;
         assign n_src   = dividend;
         assign q_src   = '0;
      end else begin : g_body
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign n_src   = n_ff[j-1];
         assign q_src   = q_ff[j-1];
      end

      assign sh   = {rem_src, n_src[NW-1]};
      assign ge   = (sh >= {1'b0, den_src});
      assign diff = sh - {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= ge ? diff[DW-1:0] : sh[DW-1:0];
            den_ff[j] <= den_src;
            n_ff[j]   <= {n_src[NW-2:0], 1'b0};
            q_ff[j]   <= {q_src[NW-2:0], ge};
         end
      end
   end

   assign quotient = q_ff[NW-1];

endmodule

>>> src/lidar_range_image_projection_unit.sv
// ----------------------------------------------------------------------------
// lidar_range_image_projection_unit
// Projects a lidar point onto a cell of a range image and gives its range.
// ----------------------------------------------------------------------------
//   Channel  Ports                       Direction  Handshake
//   req      req_point_x/y/z             in         req_valid / req_ready
//   rsp      rsp_accepted ... range_mm   out        rsp_valid / rsp_ready
//   csr      csr_index, csr_wdata        in         csr_write
//
// One word is taken every cycle unless a result waits at the output. A result
// passes through the squares stage, the sums stage, the 26-step square root of the
// horizontal range, the 23-stage elevation CORDIC (a quarter-turn stage and
// 22 iterations), one dividend stage, the 16-step row divider and two stages
// of checks and output.
// Reset clears the valid bits and loads the register defaults.
// While a result waits at the output the whole pipeline holds and req_ready
// is low; nothing moves, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lidar_range_image_projection_unit #(
   parameter int ROWS    = 16,
   parameter int COLUMNS = 1800
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [lrip_pkg::COORD_W-1:0]    req_point_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_accepted,
   output logic [1:0]                             rsp_reject_code,
   output logic [3:0]                             rsp_ring_row,
   output logic [10:0]                            rsp_azimuth_column,
   output logic [14:0]                            rsp_cell_index,
   output logic [17:0]                            rsp_range_mm,
   input  logic                                   csr_write,
   input  logic [lrip_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lrip_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CW   = lrip_pkg::COORD_W;
   localparam int AW   = lrip_pkg::ANGLE_W;
   localparam int NW   = lrip_pkg::DIV_NUM_W;
   localparam int DW   = lrip_pkg::DIV_DEN_W;
   localparam int IW   = lrip_pkg::CORDIC_IN_W;
   localparam int RW   = lrip_pkg::RNG_W;

   // Stage positions, counted in registers after the input.
   localparam int P_SUM = 2;
   localparam int P_RNG = P_SUM + lrip_pkg::RNG_W;
   localparam int P_HX  = P_SUM + lrip_pkg::HX_W;
   localparam int P_AZ  = P_SUM + lrip_pkg::CORDIC_LAT;
   localparam int P_EL  = P_HX + lrip_pkg::CORDIC_LAT;
   localparam int P_DIV = P_EL + 1;
   localparam int P_CHK = P_DIV + NW + 1;

   localparam int Z_DLY    = P_HX - P_SUM;
   localparam int AZ_DLY   = P_EL - P_AZ;
   localparam int RNG_DLY  = P_DIV + NW - P_RNG;
   localparam int SIGN_DLY = NW;

   localparam logic signed [17:0] COLS_S = 18'(COLUMNS);
   localparam logic signed [17:0] HALF_S = 18'(COLUMNS / 2);

   logic advance;
   logic [P_CHK-1:0] vld_ff;

   // Configuration registers.
   logic signed [lrip_pkg::LOW_ELEV_W-1:0] low_elev_ff;
   logic [lrip_pkg::STEP_W-1:0]            elev_step_ff;
   logic [lrip_pkg::STEP_W-1:0]            azim_step_ff;
   logic [lrip_pkg::MIN_RANGE_W-1:0]       min_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_elev_ff  <= lrip_pkg::LOW_ELEV_RESET;
         elev_step_ff <= lrip_pkg::ELEV_STEP_RESET;
         azim_step_ff <= lrip_pkg::AZIM_STEP_RESET;
         min_range_ff <= lrip_pkg::MIN_RANGE_RESET;
      end else if (csr_write) begin
         case (lrip_pkg::csr_index_type'(csr_index))
            lrip_pkg::CSR_LOWEST_ELEVATION: low_elev_ff  <= csr_wdata[14:0];
            lrip_pkg::CSR_ELEVATION_STEP:   elev_step_ff <= csr_wdata[13:0];
            lrip_pkg::CSR_AZIMUTH_STEP:     azim_step_ff <= csr_wdata[13:0];
            lrip_pkg::CSR_MIN_RANGE:        min_range_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[P_CHK-2:0], req_valid};
         rsp_valid_ff <= vld_ff[P_CHK-1];
      end
   end

   // ---------------------------------------------------------------- squares
   logic signed [35:0] sqx_in, sqy_in, sqz_in;
   logic [lrip_pkg::SQ_W-1:0] s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic signed [CW-1:0] s1_x_ff, s1_y_ff, s1_z_ff;

   assign sqx_in = 36'(req_point_x) * 36'(req_point_x);
   assign sqy_in = 36'(req_point_y) * 36'(req_point_y);
   assign sqz_in = 36'(req_point_z) * 36'(req_point_z);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sqx_ff <= sqx_in[lrip_pkg::SQ_W-1:0];
         s1_sqy_ff <= sqy_in[lrip_pkg::SQ_W-1:0];
         s1_sqz_ff <= sqz_in[lrip_pkg::SQ_W-1:0];
         s1_x_ff   <= req_point_x;
         s1_y_ff   <= req_point_y;
         s1_z_ff   <= req_point_z;
      end
   end

   // ---------------------------------------------------------------- sums
   logic [lrip_pkg::HSQ_W-1:0] hsq_in;
   logic [lrip_pkg::RSQ_W-1:0] rsq_in;
   logic [lrip_pkg::HSQ_W-1:0] s2_hsq_ff;
   logic [lrip_pkg::RSQ_W-1:0] s2_rsq_ff;
   logic signed [CW-1:0] s2_x_ff, s2_y_ff, s2_z_ff;

   assign hsq_in = 36'(s1_sqx_ff) + 36'(s1_sqy_ff);
   assign rsq_in = hsq_in + 36'(s1_sqz_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_hsq_ff <= hsq_in;
         s2_rsq_ff <= rsq_in;
         s2_x_ff   <= s1_x_ff;
         s2_y_ff   <= s1_y_ff;
         s2_z_ff   <= s1_z_ff;
      end
   end

   // ---------------------------------------------------------------- roots
   logic [lrip_pkg::HX_W-1:0] hx_root;
   logic [RW-1:0]             rng_root;

   lrip_isqrt #(.RootW(lrip_pkg::HX_W)) u_hx_root (
      .clock    (clock),
      .advance  (advance),
      .radicand ({s2_hsq_ff, 16'b0}),
      .root     (hx_root)
   );

   lrip_isqrt #(.RootW(lrip_pkg::RNG_W)) u_rng_root (
      .clock    (clock),
      .advance  (advance),
      .radicand (s2_rsq_ff),
      .root     (rng_root)
   );

   // ---------------------------------------------------------------- angles
   logic signed [IW-1:0] az_a, az_b, el_a, el_b;
   logic signed [AW-1:0] az_angle, el_angle;
   logic signed [CW-1:0] z_dly_ff  [Z_DLY];
   logic signed [AW-1:0] az_dly_ff [AZ_DLY];

   always_ff @(posedge clock) begin
      if (advance) begin
         z_dly_ff[0]  <= s2_z_ff;
         az_dly_ff[0] <= az_angle;
         for (int i = 1; i < Z_DLY; i++) begin
            z_dly_ff[i] <= z_dly_ff[i-1];
         end
         for (int i = 1; i < AZ_DLY; i++) begin
            az_dly_ff[i] <= az_dly_ff[i-1];
         end
      end
   end

   assign az_a = IW'(signed'({s2_x_ff, 8'b0}));
   assign az_b = IW'(signed'({s2_y_ff, 8'b0}));
   assign el_a = IW'(signed'({z_dly_ff[Z_DLY-1], 8'b0}));
   assign el_b = signed'({1'b0, hx_root});

   lrip_cordic u_az_cordic (
      .clock   (clock),
      .advance (advance),
      .in_a    (az_a),
      .in_b    (az_b),
      .angle   (az_angle)
   );

   lrip_cordic u_el_cordic (
      .clock   (clock),
      .advance (advance),
      .in_a    (el_a),
      .in_b    (el_b),
      .angle   (el_angle)
   );

   // ---------------------------------------------------------------- dividends
   logic signed [25:0] row_diff, az_off;
   logic [25:0]        row_mag, az_mag;
   logic [26:0]        col_sum;
   logic [DW-1:0]      elev_div, azim_div;
   logic [NW-1:0]      s52_row_num_ff, s52_col_num_ff;
   logic               s52_row_neg_ff, s52_col_neg_ff;

   assign elev_div = (elev_step_ff == '0) ? DW'(1) : elev_step_ff;
   assign azim_div = (azim_step_ff == '0) ? DW'(1) : azim_step_ff;

   assign row_diff = 26'(el_angle) - 26'(signed'({low_elev_ff, 8'b0}));
   assign row_mag  = row_diff[25] ? unsigned'(-row_diff) : unsigned'(row_diff);
   assign az_off   = 26'(az_dly_ff[AZ_DLY-1]) - 26'(lrip_pkg::DEG90);
   assign az_mag   = az_off[25] ? unsigned'(-az_off) : unsigned'(az_off);

   // Rounding half away from zero: add half a column before the divide.
   assign col_sum  = 27'(az_mag) + 27'({azim_div, 7'b0});

   always_ff @(posedge clock) begin
      if (advance) begin
         s52_row_num_ff <= row_mag[23:8];
         s52_row_neg_ff <= row_diff[25];
         s52_col_num_ff <= col_sum[23:8];
         s52_col_neg_ff <= az_off[25];
      end
   end

   // ---------------------------------------------------------------- dividers
   logic [NW-1:0] row_q, col_q;
   logic [1:0]    sign_dly_ff [SIGN_DLY];
   logic [RW-1:0] rng_dly_ff  [RNG_DLY];

   lrip_div u_row_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (s52_row_num_ff),
      .divisor  (elev_div),
      .quotient (row_q)
   );

   lrip_div u_col_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (s52_col_num_ff),
      .divisor  (azim_div),
      .quotient (col_q)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         sign_dly_ff[0] <= {s52_row_neg_ff, s52_col_neg_ff};
         rng_dly_ff[0]  <= rng_root;
         for (int i = 1; i < SIGN_DLY; i++) begin
            sign_dly_ff[i] <= sign_dly_ff[i-1];
         end
         for (int i = 1; i < RNG_DLY; i++) begin
            rng_dly_ff[i] <= rng_dly_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- row, column
   logic                 row_neg, col_neg;
   logic                 s69_row_bad_ff;
   logic [NW-1:0]        s69_row_ff;
   logic [29:0]          s69_rowc_ff;
   logic signed [17:0]   s69_col_ff;
   logic [RW-1:0]        s69_rng_ff;

   assign row_neg = sign_dly_ff[SIGN_DLY-1][1];
   assign col_neg = sign_dly_ff[SIGN_DLY-1][0];

   // A quotient between -1 and 0 truncates to row zero.
   always_ff @(posedge clock) begin
      if (advance) begin
         s69_row_bad_ff <= (row_q != '0) && (row_neg || (row_q >= NW'(ROWS)));
         s69_row_ff     <= row_q;
         s69_rowc_ff    <= 30'(row_q) * 30'(COLUMNS);
         s69_col_ff     <= col_neg ? HALF_S + signed'(18'(col_q))
                                   : HALF_S - signed'(18'(col_q));
         s69_rng_ff     <= rng_dly_ff[RNG_DLY-1];
      end
   end

   // ---------------------------------------------------------------- result
   logic signed [17:0]        col_wrap;
   logic                      col_bad, too_near, ok;
   logic [29:0]               idx_full;
   lrip_pkg::reject_code_type code;

   logic                      rsp_accepted_ff;
   logic [1:0]                rsp_code_ff;
   logic [3:0]                rsp_row_ff;
   logic [10:0]               rsp_col_ff;
   logic [14:0]               rsp_idx_ff;
   logic [17:0]               rsp_rng_ff;

   assign col_wrap = (s69_col_ff >= COLS_S) ? s69_col_ff - COLS_S : s69_col_ff;
   assign col_bad  = col_wrap[17] || (col_wrap >= COLS_S);
   assign too_near = (s69_rng_ff < RW'(min_range_ff));
   assign idx_full = s69_rowc_ff + 30'(unsigned'(col_wrap));

   always_comb begin
      if (s69_row_bad_ff) begin
         code = lrip_pkg::REJ_ROW;
      end else if (col_bad) begin
         code = lrip_pkg::REJ_COL;
      end else if (too_near) begin
         code = lrip_pkg::REJ_NEAR;
      end else begin
         code = lrip_pkg::REJ_NONE;
      end
   end

   assign ok = (code == lrip_pkg::REJ_NONE);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_accepted_ff <= ok;
         rsp_code_ff     <= code;
         rsp_row_ff      <= ok ? s69_row_ff[3:0] : 4'b0;
         rsp_col_ff      <= ok ? col_wrap[10:0] : 11'b0;
         rsp_idx_ff      <= ok ? idx_full[14:0] : 15'b0;
         rsp_rng_ff      <= s69_rng_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_reject_code    = rsp_code_ff;
   assign rsp_ring_row       = rsp_row_ff;
   assign rsp_azimuth_column = rsp_col_ff;
   assign rsp_cell_index     = rsp_idx_ff;
   assign rsp_range_mm       = rsp_rng_ff;

endmodule

>>> src/lrip_checker.sv
// ----------------------------------------------------------------------------
// lrip_checker
// Port-level checks of the range-image projection unit, bound to the top.
// ----------------------------------------------------------------------------
module lrip_checker #(
   parameter int ROWS    = 16,
   parameter int COLUMNS = 1800
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [17:0] req_point_x,
   input logic [17:0] req_point_y,
   input logic [17:0] req_point_z,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic [1:0]  rsp_reject_code,
   input logic [3:0]  rsp_ring_row,
   input logic [10:0] rsp_azimuth_column,
   input logic [14:0] rsp_cell_index,
   input logic [17:0] rsp_range_mm
);

   // A held result keeps its range, reject code and cell index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_mm)
                                 && $stable(rsp_reject_code)
                                 && $stable(rsp_cell_index))
      else $error("held result changed");

   // A waiting point keeps its word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_point_x)
                                 && $stable(req_point_y) && $stable(req_point_z))
      else $error("held point changed");

   // The pipeline only stops for a result that is not taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input stalled without output back-pressure");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accepted == (rsp_reject_code == lrip_pkg::REJ_NONE)
         && (rsp_accepted || (rsp_ring_row == 4'b0
         && rsp_azimuth_column == 11'b0 && rsp_cell_index == 15'b0)))
      else $error("accepted flag or cell disagrees with reject code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> 32'(rsp_azimuth_column) < COLUMNS
         && 32'(rsp_ring_row) < ROWS)
      else $error("accepted cell outside the image");

endmodule

bind lidar_range_image_projection_unit lrip_checker #(
   .ROWS    (ROWS),
   .COLUMNS (COLUMNS)
) u_lrip_checker (.*);

>>> dv/lidar_range_image_projection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_image_projection_unit_tb
// Drives lidar points into the projection unit under several register
// settings, predicts each cell, reject code and range with its own CORDIC
// and square root, and compares every result word in order.
// ----------------------------------------------------------------------------
module lidar_range_image_projection_unit_tb;

   localparam int ROWS     = 16;
   localparam int COLUMNS  = 1800;
   localparam int LATENCY  = 70;
   localparam int WD_LIMIT = 2000;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  reject_code;
      logic [3:0]  ring_row;
      logic [10:0] azimuth_column;
      logic [14:0] cell_index;
      logic [17:0] range_mm;
   } cell_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [lrip_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [lrip_pkg::COORD_W-1:0] req_point_y = '0;
   logic signed [lrip_pkg::COORD_W-1:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_accepted;
   logic [1:0] rsp_reject_code;
   logic [3:0] rsp_ring_row;
   logic [10:0] rsp_azimuth_column;
   logic [14:0] rsp_cell_index;
   logic [17:0] rsp_range_mm;
   logic csr_write = 0;
   logic [lrip_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lrip_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   bit rsp_quiet = 0;

   // Shadow copies of the projection registers.
   longint low_elev, elev_step, azim_step, near_limit;

   lidar_range_image_projection_unit #(.ROWS(ROWS), .COLUMNS(COLUMNS)) DUT (.*);

   always #2 clock = ~clock;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   // Vectoring CORDIC: angle of (re, im) in 1/256 centidegree.
   function automatic longint cordic_angle(input longint im_in, input longint re_in);
      longint re, im, ang, dre, dim;
      re = re_in;
      im = im_in;
      ang = 0;
      if (im_in == 0 && re_in == 0) return 0;
      if (re_in < 0) begin
         if (im_in >= 0) begin
            re = im_in; im = -re_in; ang = lrip_pkg::DEG90;
         end else begin
            re = -im_in; im = re_in; ang = -lrip_pkg::DEG90;
         end
      end
      for (int i = 0; i < lrip_pkg::CORDIC_ITER; i++) begin
         dre = floor_shift(im, i);
         dim = floor_shift(re, i);
         if (im >= 0) begin
            re += dre; im -= dim; ang += lrip_pkg::ATAN_TAB[i];
         end else begin
            re -= dre; im += dim; ang -= lrip_pkg::ATAN_TAB[i];
         end
      end
      return ang;
   endfunction

   function automatic cell_result_type project_point(input longint x, input longint y,
                                                     input longint z);
      cell_result_type r;
      longint hsq, rng, hx, esz, asz, row, qn, mag, q, col;
      lrip_pkg::reject_code_type code;
      hsq = x * x + y * y;
      rng = int_sqrt(hsq + z * z);
      hx = int_sqrt(hsq << 16);
      esz = (elev_step == 0 ? 1 : elev_step) * 256;
      asz = (azim_step == 0 ? 1 : azim_step) * 256;
      row = (cordic_angle(z * 256, hx) - low_elev * 256) / esz;
      qn = cordic_angle(x * 256, y * 256) - 64'sd9000 * 256;
      mag = qn < 0 ? -qn : qn;
      q = (2 * mag + asz) / (2 * asz);
      if (qn < 0) q = -q;
      col = COLUMNS / 2 - q;
      if (col >= COLUMNS) col -= COLUMNS;
      if (row < 0 || row >= ROWS) code = lrip_pkg::REJ_ROW;
      else if (col < 0 || col >= COLUMNS) code = lrip_pkg::REJ_COL;
      else if (rng < near_limit) code = lrip_pkg::REJ_NEAR;
      else code = lrip_pkg::REJ_NONE;
      r = '0;
      r.accepted = (code == lrip_pkg::REJ_NONE);
      r.reject_code = code;
      if (code == lrip_pkg::REJ_NONE) begin
         r.ring_row = row[3:0];
         r.azimuth_column = col[10:0];
         r.cell_index = 15'(row * COLUMNS + col);
      end
      r.range_mm = rng[17:0];
      return r;
   endfunction

   class cell_scoreboard_type;
      cell_result_type pending[$];

      function void note_point(input longint x, input longint y, input longint z);
         pending = {pending, project_point(x, y, z)};
      endfunction

      task check_cell(input cell_result_type got);
         cell_result_type want;
         if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.accepted != want.accepted) report("accepted", got.accepted, want.accepted);
         if (got.reject_code != want.reject_code)
            report("reject_code", got.reject_code, want.reject_code);
         if (got.ring_row != want.ring_row) report("ring_row", got.ring_row, want.ring_row);
         if (got.azimuth_column != want.azimuth_column)
            report("azimuth_column", got.azimuth_column, want.azimuth_column);
         if (got.cell_index != want.cell_index)
            report("cell_index", got.cell_index, want.cell_index);
         if (got.range_mm != want.range_mm) report("range_mm", got.range_mm, want.range_mm);
      endtask
   endclass

   cell_scoreboard_type board = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_point(req_point_x, req_point_y, req_point_z);
         if (rsp_valid && rsp_ready)
            board.check_cell({rsp_accepted, rsp_reject_code, rsp_ring_row,
                              rsp_azimuth_column, rsp_cell_index, rsp_range_mm});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WD_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: stalls in random bursts unless the run is in its quiet part.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!rsp_quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   task automatic write_reg(input lrip_pkg::csr_index_type idx, input longint value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value[lrip_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         lrip_pkg::CSR_LOWEST_ELEVATION: low_elev = longint'(signed'(value[14:0]));
         lrip_pkg::CSR_ELEVATION_STEP:   elev_step = value[13:0];
         lrip_pkg::CSR_AZIMUTH_STEP:     azim_step = value[13:0];
         lrip_pkg::CSR_MIN_RANGE:        near_limit = value[16:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_point(input longint x, input longint y, input longint z);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 17);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_point_x <= x[17:0];
      req_point_y <= y[17:0];
      req_point_z <= z[17:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic longint rand_coord(input int mode);
      case (mode)
         0: return longint'($urandom_range(0, 262143)) - 131072;
         1: return longint'($urandom_range(0, 8000)) - 4000;
         2: return longint'($urandom_range(0, 60)) - 30;
         default: return $urandom_range(0, 1) ? 131071 : -131072;
      endcase
   endfunction

   task automatic random_phase(input int count);
      longint x, y, z;
      for (int i = 0; i < count; i++) begin
         x = rand_coord($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
         y = rand_coord($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
         // Mostly points near the sensor's rings so that rows land inside.
         z = $urandom_range(0, 3) == 0 ? rand_coord($urandom_range(0, 3))
                                       : (x + y) / longint'($urandom_range(4, 40)) *
                                         ($urandom_range(0, 1) ? 64'sd1 : -64'sd1);
         send_point(x, y, z);
      end
   endtask

   initial begin
      low_elev = lrip_pkg::LOW_ELEV_RESET;
      elev_step = lrip_pkg::ELEV_STEP_RESET;
      azim_step = lrip_pkg::AZIM_STEP_RESET;
      near_limit = lrip_pkg::MIN_RANGE_RESET;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed points at the reset setting.
      send_point(0, 0, 0);
      send_point(131071, 131071, 131071);
      send_point(-131072, -131072, -131072);
      send_point(131071, 0, 0);
      send_point(-131072, 0, 0);
      send_point(0, 131071, 0);
      send_point(0, -131072, 0);
      send_point(0, 5000, 0);
      send_point(0, -5000, 10);
      send_point(-5000, -1, 0);
      send_point(-5000, 1, 0);
      send_point(5000, 0, -400);
      send_point(5000, 0, 2000);
      send_point(5000, 0, 500);
      send_point(300, 300, 0);
      send_point(0, 0, 131071);
      send_point(0, 0, -131072);
      send_point(20000, 5, 3000);
      send_point(-1, -1, -1);
      send_point(2, -3, 1);
      stop_sending();
      wait_drained();

      random_phase(300);
      stop_sending();
      wait_drained();

      write_reg(lrip_pkg::CSR_LOWEST_ELEVATION, -9000);
      write_reg(lrip_pkg::CSR_ELEVATION_STEP, 9000);
      write_reg(lrip_pkg::CSR_AZIMUTH_STEP, 9000);
      write_reg(lrip_pkg::CSR_MIN_RANGE, 0);
      random_phase(300);
      stop_sending();
      wait_drained();

      write_reg(lrip_pkg::CSR_LOWEST_ELEVATION, 9000);
      write_reg(lrip_pkg::CSR_ELEVATION_STEP, 1);
      write_reg(lrip_pkg::CSR_AZIMUTH_STEP, 1);
      write_reg(lrip_pkg::CSR_MIN_RANGE, 131071);
      random_phase(250);
      stop_sending();
      wait_drained();

      // A zero step counts as one; the elevation step is written as zero here.
      write_reg(lrip_pkg::CSR_LOWEST_ELEVATION, -16384);
      write_reg(lrip_pkg::CSR_ELEVATION_STEP, 0);
      write_reg(lrip_pkg::CSR_AZIMUTH_STEP, 16383);
      write_reg(lrip_pkg::CSR_MIN_RANGE, 65535);
      random_phase(200);
      stop_sending();
      wait_drained();

      write_reg(lrip_pkg::CSR_LOWEST_ELEVATION, 16383);
      write_reg(lrip_pkg::CSR_ELEVATION_STEP, 16383);
      write_reg(lrip_pkg::CSR_AZIMUTH_STEP, 0);
      write_reg(lrip_pkg::CSR_MIN_RANGE, 500);
      random_phase(200);
      stop_sending();
      wait_drained();

      write_reg(lrip_pkg::CSR_LOWEST_ELEVATION, -2500);
      write_reg(lrip_pkg::CSR_ELEVATION_STEP, 300);
      write_reg(lrip_pkg::CSR_AZIMUTH_STEP, 20);
      write_reg(lrip_pkg::CSR_MIN_RANGE, 200);
      random_phase(300);

      // Last part of the run without any idling.
      quiet = 1;
      rsp_quiet = 1;
      random_phase(280);
      stop_sending();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
